// ===== hdl/dvhs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dvhs_pkg;

  localparam int RANGE_W     = 10;
  localparam int CNT_W       = 6;
  localparam int DEN_W       = CNT_W + 1;
  localparam int OUT_VALUE_W = 10;
  localparam int MEAN_W      = 17;
  localparam int PCT_W       = 14;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int OUT_DEPTH   = 2;

  localparam logic [RANGE_W-1:0] RANGE_LOW_RESET  = RANGE_W'(165);
  localparam logic [RANGE_W-1:0] RANGE_HIGH_RESET = RANGE_W'(175);
  localparam int SCALE     = 100;
  localparam int MEAN_MULT = 2 * SCALE;
  localparam int PCT_MULT  = 2 * SCALE * SCALE;

  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LOW  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_HIGH = CFG_INDEX_W'(1);

  typedef enum logic [1:0] {
    OP_TAKE,
    OP_END,
    OP_TAKE_END
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_range;
  } cls_t;

  typedef enum logic [1:0] {
    ROW_DISTINCT = 2'd0,
    ROW_SUMMARY  = 2'd1,
    ROW_EMPTY    = 2'd2
  } row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [OUT_VALUE_W-1:0] value;
    logic [CNT_W-1:0]       count;
    logic [MEAN_W-1:0]      mean;
    logic [PCT_W-1:0]       percent;
    logic                   last;
  } row_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_REPORT_RD,
    ST_REPORT_WR,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_PCT_GO,
    ST_PCT_WAIT,
    ST_SUMMARY,
    ST_EMPTY_ROW
  } back_state_t;

endpackage
`default_nettype wire

// ===== hdl/dvhs_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dvhs_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/dvhs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dvhs_front #(
  parameter int VALUE_BITS = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [VALUE_BITS-1:0]           sample_value,
  input  wire logic                            has_value,
  input  wire logic                            end_of_set,
  input  wire logic                            cfg_we,
  input  wire logic [dvhs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [dvhs_pkg::RANGE_W-1:0]     cfg_data,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output logic [VALUE_BITS-1:0]                q_value,
  output dvhs_pkg::cls_t                       q_cls
);
  import dvhs_pkg::*;

  localparam int CMP_W = (VALUE_BITS > RANGE_W) ? VALUE_BITS : RANGE_W;

  logic [RANGE_W-1:0] range_low;
  logic [RANGE_W-1:0] range_high;
  logic [CMP_W-1:0]   v_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= RANGE_LOW_RESET;
      range_high <= RANGE_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANGE_LOW:  range_low  <= cfg_data;
        REG_RANGE_HIGH: range_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign v_ext   = CMP_W'(sample_value);
  assign full    = q_full;
  assign q_value = sample_value;

  // A beat with neither a value nor an end mark changes nothing and is dropped here.
  assign q_push = push && !q_full && (has_value || end_of_set);

  always_comb begin
    q_cls.in_range = (v_ext >= CMP_W'(range_low)) && (v_ext <= CMP_W'(range_high));
    if (has_value) begin
      q_cls.op = end_of_set ? OP_TAKE_END : OP_TAKE;
    end else begin
      q_cls.op = OP_END;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/dvhs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dvhs_div #(
  parameter int NUM_W = 25
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [NUM_W-1:0]           num,
  input  wire logic [dvhs_pkg::DEN_W-1:0] den,
  output logic                            done,
  output logic [NUM_W-1:0]                quot
);
  import dvhs_pkg::*;

  localparam int SW = $clog2(NUM_W);

  logic              busy;
  logic [SW-1:0]     steps;
  logic [NUM_W-1:0]  work;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  divisor;
  logic [DEN_W:0]    rem_sh;
  logic              fits;

  assign rem_sh = {rem, work[NUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, divisor});
  assign quot   = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work    <= num;
      rem     <= '0;
      divisor <= den;
      steps   <= SW'(NUM_W - 1);
    end else if (busy) begin
      rem   <= fits ? DEN_W'(rem_sh - {1'b0, divisor}) : DEN_W'(rem_sh);
      work  <= {work[NUM_W-2:0], fits};
      steps <= steps - SW'(1);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/dvhs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dvhs_back #(
  parameter int CAPACITY   = 63,
  parameter int VALUE_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_empty,
  input  wire logic [VALUE_BITS-1:0] q_value,
  input  wire dvhs_pkg::cls_t        q_cls,
  output logic                       q_pop,
  input  wire logic                  o_full,
  output logic                       o_push,
  output dvhs_pkg::row_t             o_row
);
  import dvhs_pkg::*;

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SUM_W = VALUE_BITS + CNT_W;
  localparam int NUM_W = (VALUE_BITS + 15 > 21) ? VALUE_BITS + 15 : 21;

  back_state_t state, state_next;

  logic [VALUE_BITS-1:0] mem_val [CAPACITY];
  logic [CNT_W-1:0]      mem_cnt [CAPACITY];
  logic [VALUE_BITS-1:0] rd_val;
  logic [CNT_W-1:0]      rd_cnt;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  mem_we;
  logic [AW-1:0]         wr_addr;
  logic [CNT_W-1:0]      wr_cnt;

  logic [VALUE_BITS-1:0] cur_value;
  logic                  cur_in_range;
  logic                  cur_end;
  logic [CNT_W-1:0]      idx;
  logic                  pend;
  logic [AW-1:0]         pend_idx;
  logic [CNT_W-1:0]      used;
  logic [CNT_W-1:0]      total;
  logic [SUM_W-1:0]      sum;
  logic [CNT_W-1:0]      inr;
  logic [MEAN_W-1:0]     mean_q;
  logic [PCT_W-1:0]      pct_q;

  logic                  item_take;
  logic                  item_end;
  logic                  take_ok;
  logic                  hit;
  logic                  search_done;
  logic                  room;
  logic                  last_entry;

  logic                  div_start;
  logic [NUM_W-1:0]      div_num;
  logic [DEN_W-1:0]      div_den;
  logic                  div_done;
  logic [NUM_W-1:0]      div_quot;

  dvhs_div #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign item_take   = (q_cls.op == OP_TAKE) || (q_cls.op == OP_TAKE_END);
  assign item_end    = (q_cls.op == OP_END) || (q_cls.op == OP_TAKE_END);
  assign take_ok     = item_take && (total < CNT_W'(CAPACITY));
  assign hit         = pend && (rd_val == cur_value);
  assign search_done = hit || (idx == used);
  assign room        = used < CNT_W'(CAPACITY);
  assign last_entry  = (idx + CNT_W'(1)) == used;
  assign div_den     = {total, 1'b0};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          if (take_ok) begin
            state_next = ST_SEARCH;
          end else if (item_end) begin
            state_next = (total == '0) ? ST_EMPTY_ROW : ST_REPORT_RD;
          end
        end
      end
      ST_SEARCH: begin
        if (search_done) begin
          state_next = cur_end ? ST_REPORT_RD : ST_IDLE;
        end
      end
      ST_REPORT_RD: state_next = ST_REPORT_WR;
      ST_REPORT_WR: begin
        if (!o_full) begin
          state_next = last_entry ? ST_MEAN_GO : ST_REPORT_RD;
        end
      end
      ST_MEAN_GO: state_next = ST_MEAN_WAIT;
      ST_MEAN_WAIT: begin
        if (div_done) begin
          state_next = ST_PCT_GO;
        end
      end
      ST_PCT_GO: state_next = ST_PCT_WAIT;
      ST_PCT_WAIT: begin
        if (div_done) begin
          state_next = ST_SUMMARY;
        end
      end
      ST_SUMMARY, ST_EMPTY_ROW: begin
        if (!o_full) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx[AW-1:0];
    mem_we    = 1'b0;
    wr_addr   = pend_idx;
    wr_cnt    = rd_cnt + CNT_W'(1);
    o_push    = 1'b0;
    o_row     = '0;
    div_start = 1'b0;
    div_num   = NUM_W'(sum) * NUM_W'(MEAN_MULT) + NUM_W'(total);
    unique case (state)
      ST_IDLE: q_pop = !q_empty;
      ST_SEARCH: begin
        if (hit) begin
          mem_we = 1'b1;
        end else if (search_done) begin
          mem_we  = room;
          wr_addr = used[AW-1:0];
          wr_cnt  = CNT_W'(1);
        end else begin
          rd_en = 1'b1;
        end
      end
      ST_REPORT_RD: rd_en = 1'b1;
      ST_REPORT_WR: begin
        o_push      = !o_full;
        o_row.kind  = ROW_DISTINCT;
        o_row.value = OUT_VALUE_W'(rd_val);
        o_row.count = rd_cnt;
      end
      ST_MEAN_GO: div_start = 1'b1;
      ST_PCT_GO: begin
        div_start = 1'b1;
        div_num   = NUM_W'(inr) * NUM_W'(PCT_MULT) + NUM_W'(total);
      end
      ST_SUMMARY: begin
        o_push        = !o_full;
        o_row.kind    = ROW_SUMMARY;
        o_row.mean    = mean_q;
        o_row.percent = pct_q;
        o_row.last    = 1'b1;
      end
      ST_EMPTY_ROW: begin
        o_push     = !o_full;
        o_row.kind = ROW_EMPTY;
        o_row.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_val[wr_addr] <= cur_value;
      mem_cnt[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      rd_val <= mem_val[rd_addr];
      rd_cnt <= mem_cnt[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
      used  <= '0;
      total <= '0;
      sum   <= '0;
      inr   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          pend <= 1'b0;
        end
        ST_SEARCH: begin
          if (!search_done) begin
            pend <= 1'b1;
          end else begin
            total <= total + CNT_W'(1);
            sum   <= sum + SUM_W'(cur_value);
            inr   <= inr + CNT_W'(cur_in_range);
            if (!hit && room) begin
              used <= used + CNT_W'(1);
            end
          end
        end
        ST_SUMMARY, ST_EMPTY_ROW: begin
          if (!o_full) begin
            used  <= '0;
            total <= '0;
            sum   <= '0;
            inr   <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          cur_value    <= q_value;
          cur_in_range <= q_cls.in_range;
          cur_end      <= item_end;
          idx          <= '0;
        end
      end
      ST_SEARCH: begin
        if (!search_done) begin
          idx      <= idx + CNT_W'(1);
          pend_idx <= idx[AW-1:0];
        end else begin
          idx <= '0;
        end
      end
      ST_REPORT_WR: begin
        if (!o_full) begin
          idx <= idx + CNT_W'(1);
        end
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          mean_q <= div_quot[MEAN_W-1:0];
        end
      end
      ST_PCT_WAIT: begin
        if (div_done) begin
          pct_q <= div_quot[PCT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/distinct_value_histogram_stats.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel    Handshake         Beat
// input      push / full       sample_value, has_value, end_of_set
// result     empty / pop       row_kind, distinct_value, occurrences, mean_hundredths,
//                              percent_hundredths, last_row
// config     cfg_we            cfg_index, cfg_data (written at once, no read-back)
//
// A value is handled in the back end by a serial search of the table memory, one
// entry read per cycle; the input queue absorbs two beats meanwhile.
// A non-empty set's report lists each table row, then runs two serial divisions of one
// quotient bit per cycle (VALUE_BITS + 15 bits, at least 21) for mean and percentage.
// Reset clears the counters and queues; the table memory needs no clearing.
// A full result queue stalls only the report; input beats keep queuing until full.
module distinct_value_histogram_stats #(
  parameter int CAPACITY   = 63,
  parameter int VALUE_BITS = 10
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [VALUE_BITS-1:0]            sample_value,
  input  wire logic                             has_value,
  input  wire logic                             end_of_set,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [1:0]                            row_kind,
  output logic [dvhs_pkg::OUT_VALUE_W-1:0]      distinct_value,
  output logic [dvhs_pkg::CNT_W-1:0]            occurrences,
  output logic [dvhs_pkg::MEAN_W-1:0]           mean_hundredths,
  output logic [dvhs_pkg::PCT_W-1:0]            percent_hundredths,
  output logic                                  last_row,
  input  wire logic                             cfg_we,
  input  wire logic [dvhs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [dvhs_pkg::RANGE_W-1:0]     cfg_data
);
  import dvhs_pkg::*;

  localparam int ITEM_W = VALUE_BITS + $bits(cls_t);
  localparam int ROW_W  = $bits(row_t);

  logic                  fq_push;
  logic [VALUE_BITS-1:0] fq_value;
  cls_t                  fq_cls;
  logic                  iq_full;
  logic                  iq_empty;
  logic                  iq_pop;
  logic [ITEM_W-1:0]     iq_rdata;
  logic [VALUE_BITS-1:0] bq_value;
  cls_t                  bq_cls;
  logic                  oq_full;
  logic                  oq_push;
  row_t                  oq_wrow;
  logic [ROW_W-1:0]      oq_rdata;
  row_t                  head;

  dvhs_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .sample_value (sample_value),
    .has_value    (has_value),
    .end_of_set   (end_of_set),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (iq_full),
    .q_push       (fq_push),
    .q_value      (fq_value),
    .q_cls        (fq_cls)
  );

  dvhs_fifo #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata ({fq_value, fq_cls}),
    .full  (iq_full),
    .pop   (iq_pop),
    .rdata (iq_rdata),
    .empty (iq_empty)
  );

  assign bq_value = iq_rdata[ITEM_W-1 -: VALUE_BITS];
  assign bq_cls   = cls_t'(iq_rdata[$bits(cls_t)-1:0]);

  dvhs_back #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (iq_empty),
    .q_value (bq_value),
    .q_cls   (bq_cls),
    .q_pop   (iq_pop),
    .o_full  (oq_full),
    .o_push  (oq_push),
    .o_row   (oq_wrow)
  );

  dvhs_fifo #(.WIDTH(ROW_W), .DEPTH(OUT_DEPTH)) u_row_q (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .wdata (oq_wrow),
    .full  (oq_full),
    .pop   (pop),
    .rdata (oq_rdata),
    .empty (empty)
  );

  assign head               = row_t'(oq_rdata);
  assign row_kind           = head.kind;
  assign distinct_value     = head.value;
  assign occurrences        = head.count;
  assign mean_hundredths    = head.mean;
  assign percent_hundredths = head.percent;
  assign last_row           = head.last;
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import dvhs_pkg::*;

  localparam int CAPACITY      = 63;
  localparam int VALUE_BITS    = 10;
  localparam int DIR_LEN       = 24;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_BEATS   = 10;
  localparam int SETTLE_CYCLES = 300;
  localparam int STALL_LIMIT   = 5000;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = CFG_INDEX_W'(3);

  typedef enum logic [1:0] {
    MIX_POOL,
    MIX_SINGLE,
    MIX_WIDE
  } spread_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] sample;
    logic                  has;
    logic                  ends;
    logic [1:0]            n_typed;
    row_t                  want0;
    row_t                  want1;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  logic [VALUE_BITS-1:0]  sample_value = '0;
  logic                   has_value = 1'b0;
  logic                   end_of_set = 1'b0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [1:0]             row_kind;
  logic [OUT_VALUE_W-1:0] distinct_value;
  logic [CNT_W-1:0]       occurrences;
  logic [MEAN_W-1:0]      mean_hundredths;
  logic [PCT_W-1:0]       percent_hundredths;
  logic                   last_row;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [RANGE_W-1:0]     cfg_data = '0;

  distinct_value_histogram_stats #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [OUT_VALUE_W-1:0] tab_value [CAPACITY];
  logic [CNT_W-1:0]       tab_count [CAPACITY];
  int unsigned            tab_used = 0;
  int unsigned            set_taken = 0;
  int unsigned            set_sum = 0;
  int unsigned            set_in_range = 0;
  logic [RANGE_W-1:0]     lim_low = RANGE_LOW_RESET;
  logic [RANGE_W-1:0]     lim_high = RANGE_HIGH_RESET;

  row_t fresh_rows [$];
  row_t expected_rows [$];

  int send_idle_pct = 24;
  int take_idle_pct = 59;
  int phase_beats = 0;
  int fail_count = 0;
  int stall_cycles = 0;
  int rows_checked = 0;
  int reports_seen = 0;
  int empties_seen = 0;
  int table_rows = 0;
  int widest_table = 0;

  function automatic row_t mk_row(input row_kind_t kind, input int unsigned value, count,
                                  mean, pct, input logic is_last);
    row_t r;
    r.kind    = kind;
    r.value   = OUT_VALUE_W'(value);
    r.count   = CNT_W'(count);
    r.mean    = MEAN_W'(mean);
    r.percent = PCT_W'(pct);
    r.last    = is_last;
    return r;
  endfunction

  function automatic stim_row_t plain(input logic [VALUE_BITS-1:0] v, input logic h, e);
    return '{v, h, e, 2'd0, '0, '0};
  endfunction

  task automatic tabulate(input logic [VALUE_BITS-1:0] v, input logic h, e);
    int unsigned slot;
    int unsigned n;
    fresh_rows.delete();
    if (h && set_taken < CAPACITY) begin
      slot = 0;
      while (slot < tab_used && tab_value[slot] != v) slot++;
      if (slot == tab_used) begin
        tab_value[slot] = v;
        tab_count[slot] = '0;
        tab_used++;
      end
      tab_count[slot] = tab_count[slot] + 1'b1;
      set_taken++;
      set_sum += v;
      if (v >= lim_low && v <= lim_high) set_in_range++;
    end
    if (e) begin
      if (set_taken == 0) begin
        fresh_rows.push_back(mk_row(ROW_EMPTY, 0, 0, 0, 0, 1'b1));
      end else begin
        for (int i = 0; i < tab_used; i++) begin
          fresh_rows.push_back(mk_row(ROW_DISTINCT, tab_value[i], tab_count[i], 0, 0, 1'b0));
        end
        n = set_taken;
        fresh_rows.push_back(mk_row(ROW_SUMMARY, 0, 0,
                                    (set_sum * 2 * SCALE + n) / (2 * n),
                                    (set_in_range * 2 * SCALE * SCALE + n) / (2 * n), 1'b1));
      end
      tab_used = 0;
      set_taken = 0;
      set_sum = 0;
      set_in_range = 0;
    end
  endtask

  task automatic put_beat(input stim_row_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    sample_value <= s.sample;
    has_value <= s.has;
    end_of_set <= s.ends;
    do @(posedge clk); while (full);
    tabulate(s.sample, s.has, s.ends);
    if (s.n_typed == 0) begin
      foreach (fresh_rows[i]) expected_rows.push_back(fresh_rows[i]);
    end else begin
      expected_rows.push_back(s.want0);
      if (s.n_typed == 2) expected_rows.push_back(s.want1);
    end
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value(input spread_t spread,
                                                       input logic [3:0][VALUE_BITS-1:0] pool);
    logic [VALUE_BITS-1:0] bound;
    case (spread)
      MIX_SINGLE: return pool[0];
      MIX_WIDE: return VALUE_BITS'($urandom);
      default: begin
        bound = ($urandom_range(1) == 1) ? lim_low : lim_high;
        case ($urandom_range(3))
          0: return bound + VALUE_BITS'($urandom_range(2)) - VALUE_BITS'(1);
          1: return VALUE_BITS'($urandom);
          default: return pool[$urandom_range(3)];
        endcase
      end
    endcase
  endfunction

  task automatic run_set(input int len, input spread_t spread);
    logic [3:0][VALUE_BITS-1:0] pool;
    bit joined;
    joined = (len > CAPACITY) || ($urandom_range(1) == 1);
    for (int i = 0; i < 4; i++) begin
      pool[i] = ($urandom_range(7) == 0) ? {VALUE_BITS{$urandom_range(1) == 1}}
                                         : VALUE_BITS'($urandom);
    end
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(15) == 0) put_beat(plain(VALUE_BITS'($urandom), 1'b0, 1'b0));
      put_beat(plain(pick_value(spread, pool), 1'b1, joined && k == len - 1));
      phase_beats++;
    end
    if (len == 0 || !joined) begin
      put_beat(plain(VALUE_BITS'($urandom), 1'b0, 1'b1));
      phase_beats++;
    end
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [RANGE_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_RANGE_LOW: lim_low = data;
      REG_RANGE_HIGH: lim_high = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [31:0] want, got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) pop <= ($urandom_range(99) >= take_idle_pct);

  always @(posedge clk) begin : row_check
    row_t want;
    if (!rst && pop && !empty) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: row with nothing expected: kind %0d value %0d count %0d", $time,
                 row_kind, distinct_value, occurrences);
        fail_count++;
      end else begin
        want = expected_rows.pop_front();
        check_field("row_kind", 32'(want.kind), 32'(row_kind));
        check_field("distinct_value", 32'(want.value), 32'(distinct_value));
        check_field("occurrences", 32'(want.count), 32'(occurrences));
        check_field("mean_hundredths", 32'(want.mean), 32'(mean_hundredths));
        check_field("percent_hundredths", 32'(want.percent), 32'(percent_hundredths));
        check_field("last_row", 32'(want.last), 32'(last_row));
        rows_checked++;
        if (want.kind == ROW_DISTINCT) table_rows++;
        if (want.kind == ROW_EMPTY) empties_seen++;
        if (want.last) begin
          reports_seen++;
          if (table_rows > widest_table) widest_table = table_rows;
          table_rows = 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    logic [RANGE_W-1:0] lo;
    logic [RANGE_W-1:0] hi;
    stim_row_t dir_table [DIR_LEN];
    dir_table = '{
      '{10'd0, 1'b0, 1'b1, 2'd1, mk_row(ROW_EMPTY, 0, 0, 0, 0, 1'b1), row_t'('0)},
      plain(10'd1023, 1'b0, 1'b0),
      '{10'd1023, 1'b1, 1'b1, 2'd2, mk_row(ROW_DISTINCT, 1023, 1, 0, 0, 1'b0),
        mk_row(ROW_SUMMARY, 0, 0, 102300, 0, 1'b1)},
      '{10'd0, 1'b1, 1'b1, 2'd2, mk_row(ROW_DISTINCT, 0, 1, 0, 0, 1'b0),
        mk_row(ROW_SUMMARY, 0, 0, 0, 0, 1'b1)},
      '{10'd170, 1'b1, 1'b1, 2'd2, mk_row(ROW_DISTINCT, 170, 1, 0, 0, 1'b0),
        mk_row(ROW_SUMMARY, 0, 0, 17000, 10000, 1'b1)},
      '{10'd512, 1'b0, 1'b1, 2'd1, mk_row(ROW_EMPTY, 0, 0, 0, 0, 1'b1), row_t'('0)},
      plain(10'd165, 1'b1, 1'b0),
      plain(10'd175, 1'b1, 1'b0),
      plain(10'd165, 1'b1, 1'b0),
      plain(10'd164, 1'b1, 1'b0),
      plain(10'd176, 1'b1, 1'b0),
      plain(10'd341, 1'b0, 1'b1),
      plain(10'd0, 1'b1, 1'b0),
      plain(10'd1023, 1'b1, 1'b0),
      plain(10'd0, 1'b1, 1'b0),
      plain(10'd682, 1'b1, 1'b1),
      plain(10'd1, 1'b1, 1'b0),
      plain(10'd0, 1'b1, 1'b0),
      plain(10'd0, 1'b1, 1'b0),
      plain(10'd0, 1'b1, 1'b0),
      plain(10'd0, 1'b1, 1'b0),
      plain(10'd0, 1'b1, 1'b0),
      plain(10'd0, 1'b1, 1'b0),
      plain(10'd0, 1'b1, 1'b1)
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        push <= 1'b0;
        drain();
        case (ph)
          1: begin lo = '0; hi = '1; end
          2: begin lo = '1; hi = '0; end
          3: begin lo = '0; hi = '0; end
          4: begin lo = '1; hi = '1; end
          default: begin
            lo = RANGE_W'($urandom);
            hi = RANGE_W'($urandom_range(lo, 1023));
          end
        endcase
        cfg_write(REG_RANGE_LOW, lo);
        cfg_write(ph[0] ? REG_SPARE_3 : REG_SPARE_2, RANGE_W'($urandom));
        cfg_write(REG_RANGE_HIGH, hi);
        cfg_we <= 1'b0;
      end
      if (ph < 2) begin
        send_idle_pct = 24;
        take_idle_pct = 59;
      end else if (ph < 4) begin
        send_idle_pct = 59;
        take_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end
      case (ph)
        0: foreach (dir_table[i]) put_beat(dir_table[i]);
        1: run_set(CAPACITY, MIX_WIDE);
        2: run_set(CAPACITY + 1, MIX_SINGLE);
        4: run_set(CAPACITY + $urandom_range(1, 6), MIX_WIDE);
        default: ;
      endcase
      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) begin
        run_set(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10),
                ($urandom_range(3) == 0) ? MIX_WIDE : MIX_POOL);
      end
    end
    push <= 1'b0;
    drain();
    $display("Checked %0d rows in %0d reports (%0d empty), widest table %0d entries.",
             rows_checked, reports_seen, empties_seen, widest_table);
    $display("Ranges covered: reset, full, inverted, single-point and random; three idling mixes.");
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== distinct_value_histogram_stats.f =====
hdl/dvhs_pkg.sv
hdl/dvhs_fifo.sv
hdl/dvhs_front.sv
hdl/dvhs_div.sv
hdl/dvhs_back.sv
hdl/distinct_value_histogram_stats.sv
bench/tb.sv
